>>> hdl/saos_pkg.sv
`default_nettype none

package saos_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_W-1:0]     key_t;
    typedef logic [CAPACITY-1:0][KEY_W-1:0] key_row_t;
    typedef logic [CAPACITY-1:0]         cell_vec_t;

    // actions
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_PRED   = 3'd3;
    localparam logic [2:0] ACT_SUCC   = 3'd4;
    localparam logic [2:0] ACT_KTH    = 3'd5;

    // result status
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } cell_op_t;

    typedef struct packed {
        logic lt;   // stored key below the command key
        logic gt;   // stored key above the command key
    } cell_flags_t;

    // and-or pick of one stored key by a one-hot select
    function automatic key_t select_key(input cell_vec_t sel, input key_row_t row);
        logic [KEY_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            acc = acc | ({KEY_W{sel[i]}} & row[i]);
        end
        return key_t'(acc);
    endfunction

    // number of ones in a low-aligned thermometer code
    function automatic logic [CNT_W-1:0] therm_count(input cell_vec_t t);
        logic [CNT_W-1:0] acc;
        logic             top_one;
        acc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            top_one = t[i] & ((i == CAPACITY - 1) ? 1'b1 : ~t[(i + 1) % CAPACITY]);
            acc = acc | ({CNT_W{top_one}} & CNT_W'(i + 1));
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> hdl/saos_cell.sv
`default_nettype none

module saos_cell (
    input  wire                  clk,
    input  saos_pkg::cell_op_t   op,
    input  saos_pkg::key_t       key,
    input  saos_pkg::key_t       left,
    input  saos_pkg::key_t       right,
    output saos_pkg::key_t       entry,
    output saos_pkg::cell_flags_t flags
);
    import saos_pkg::*;

    key_t entry_reg;
    key_t entry_next;

    always_comb
    begin
        case (op)
            CELL_LOAD:  entry_next = key;
            CELL_LEFT:  entry_next = left;
            CELL_RIGHT: entry_next = right;
            default:    entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign flags.lt = (entry_reg < key);
    assign flags.gt = (key < entry_reg);

endmodule

`default_nettype wire

>>> hdl/sorted_array_ordered_set_top.sv
`default_nettype none

// channel   direction  handshake             fields
// command   in         start & !busy         action, key, index
// result    out        done (one cycle)      status, value, position, occupancy,
//                                            smallest, largest, is_empty
//
// each command runs through capture, a pass over the cell row where every cell compares
// against the key and shifts with its neighbor, then a summary step that picks the
// smallest and largest keys; done rises in the cycle after that.
// a new command is taken in the cycle that done is high.
// reset clears the key count, the state and done only; cell contents are unknown until written.
// the result is never stalled: done stands for exactly one cycle, the fields hold until the next command.

module sorted_array_ordered_set_top (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire  [2:0]               action,
    input  saos_pkg::key_t           key,
    input  wire  [4:0]               index,
    output logic                     done,
    output logic [1:0]               status,
    output saos_pkg::key_t           value,
    output logic [3:0]               position,
    output logic [4:0]               occupancy,
    output saos_pkg::key_t           smallest,
    output saos_pkg::key_t           largest,
    output logic                     is_empty
);
    import saos_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUMMARY
    } state_t;

    state_t           state_reg;
    logic [2:0]       action_reg;
    key_t             key_reg;
    logic [4:0]       index_reg;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;

    logic             done_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    key_t             value_reg;
    key_t             value_next;
    logic [IDX_W-1:0] position_reg;
    logic [IDX_W-1:0] position_next;
    logic [CNT_W-1:0] occupancy_reg;
    key_t             smallest_reg;
    key_t             largest_reg;
    logic             is_empty_reg;

    key_row_t         row;
    key_row_t         left_row;
    key_row_t         right_row;
    cell_flags_t      flags [CAPACITY];
    cell_op_t         ops [CAPACITY];

    cell_vec_t        valid;
    cell_vec_t        lt_vec;
    cell_vec_t        le_vec;
    cell_vec_t        le_prev;
    cell_vec_t        lt_succ;
    cell_vec_t        rm_sel;
    cell_vec_t        kth_sel;
    cell_vec_t        pred_sel;
    cell_vec_t        succ_sel;
    cell_vec_t        last_sel;
    logic [CNT_W-1:0] lower_cnt;
    logic [CNT_W-1:0] upper_cnt;
    logic [CNT_W-1:0] kth_pos;
    logic             found;
    logic             full;
    logic             rm_ok;
    logic             kth_ok;

    assign left_row  = {row[CAPACITY-2:0], KEY_W'(0)};
    assign right_row = {row[CAPACITY-1], row[CAPACITY-1:1]};

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        saos_cell u_cell (
            .clk   (clk),
            .op    (ops[g]),
            .key   (key_reg),
            .left  (key_t'(left_row[g])),
            .right (key_t'(right_row[g])),
            .entry (row[g]),
            .flags (flags[g])
        );
    end

    assign full    = (held_reg == CNT_W'(CAPACITY));
    assign rm_ok   = (CNT_W'(index_reg) < held_reg);
    assign kth_ok  = (index_reg != 5'd0) && (CNT_W'(index_reg) <= held_reg);
    assign kth_pos = held_reg - CNT_W'(index_reg);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid[i]    = (CNT_W'(i) < held_reg);
            lt_vec[i]   = valid[i] & flags[i].lt;
            le_vec[i]   = valid[i] & ~flags[i].gt;
            rm_sel[i]   = (CNT_W'(i) == CNT_W'(index_reg));
            kth_sel[i]  = (CNT_W'(i) == kth_pos);
            last_sel[i] = (CNT_W'(i + 1) == held_reg);
        end
    end

    // neighbor views: slot below the first cell counts as "at or under key"
    assign le_prev  = {le_vec[CAPACITY-2:0], 1'b1};
    assign lt_succ  = {1'b0, lt_vec[CAPACITY-1:1]};
    assign pred_sel = lt_vec & ~lt_succ;
    assign succ_sel = valid & ~le_vec & le_prev;
    assign found    = |(le_vec & ~lt_vec);

    assign lower_cnt = therm_count(lt_vec);
    assign upper_cnt = therm_count(le_vec);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ops[i] = CELL_HOLD;
            if (state_reg == S_EXEC)
            begin
                if (action_reg == ACT_INSERT && !full)
                begin
                    if (!le_prev[i])
                        ops[i] = CELL_LEFT;
                    else if (!le_vec[i])
                        ops[i] = CELL_LOAD;
                end
                else if (action_reg == ACT_REMOVE && rm_ok)
                begin
                    if (CNT_W'(i) >= CNT_W'(index_reg))
                        ops[i] = CELL_RIGHT;
                end
            end
        end
    end

    always_comb
    begin
        status_next   = ST_MISS;
        value_next    = '0;
        position_next = '0;
        held_next     = held_reg;
        case (action_reg) inside
            ACT_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next   = ST_DONE;
                    position_next = upper_cnt[IDX_W-1:0];
                    held_next     = held_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (rm_ok)
                begin
                    status_next   = ST_DONE;
                    value_next    = select_key(rm_sel, row);
                    position_next = index_reg[IDX_W-1:0];
                    held_next     = held_reg - CNT_W'(1);
                end
            end
            ACT_SEARCH, ACT_PRED, ACT_SUCC:
            begin
                if (found)
                begin
                    if (action_reg == ACT_SEARCH)
                    begin
                        status_next   = ST_DONE;
                        value_next    = key_reg;
                        position_next = lower_cnt[IDX_W-1:0];
                    end
                    else if (action_reg == ACT_PRED)
                    begin
                        if (lower_cnt != '0)
                        begin
                            status_next   = ST_DONE;
                            value_next    = select_key(pred_sel, row);
                            position_next = lower_cnt[IDX_W-1:0];
                        end
                    end
                    else if (upper_cnt < held_reg)
                    begin
                        status_next   = ST_DONE;
                        value_next    = select_key(succ_sel, row);
                        position_next = lower_cnt[IDX_W-1:0];
                    end
                end
            end
            ACT_KTH:
            begin
                if (kth_ok)
                begin
                    status_next   = ST_DONE;
                    value_next    = select_key(kth_sel, row);
                    position_next = kth_pos[IDX_W-1:0];
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        action_reg <= action;
                        key_reg    <= key;
                        index_reg  <= index;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    done_reg     <= 1'b0;
                    status_reg   <= status_next;
                    value_reg    <= value_next;
                    position_reg <= position_next;
                    held_reg     <= held_next;
                    state_reg    <= S_SUMMARY;
                end
                S_SUMMARY:
                begin
                    occupancy_reg <= held_reg;
                    is_empty_reg  <= (held_reg == '0);
                    smallest_reg  <= (held_reg == '0) ? key_t'(0) : key_t'(row[0]);
                    largest_reg   <= select_key(last_sel, row);
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign position  = position_reg;
    assign occupancy = occupancy_reg;
    assign smallest  = smallest_reg;
    assign largest   = largest_reg;
    assign is_empty  = is_empty_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("key count beyond capacity");

    a_done_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_SUMMARY))
        else $error("result beat without a summary cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted command did not start");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == CNT_W'(CAPACITY)))
        else $error("full status while the store has room");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (occupancy == '0)))
        else $error("empty flag disagrees with occupancy");
`endif

endmodule

`default_nettype wire

>>> test/sorted_array_ordered_set_checker.sv
module sorted_array_ordered_set_checker (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire               busy,
    input  wire  [2:0]        action,
    input  saos_pkg::key_t    key,
    input  wire  [4:0]        index,
    input  wire               done,
    input  wire  [1:0]        status,
    input  saos_pkg::key_t    value,
    input  wire  [3:0]        position,
    input  wire  [4:0]        occupancy,
    input  saos_pkg::key_t    smallest,
    input  saos_pkg::key_t    largest,
    input  wire               is_empty,
    output int                failures,
    output int                outstanding,
    output int                checked,
    output int                full_hits
);

    import saos_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        key_t       value;
        logic [3:0] position;
        logic [4:0] occupancy;
        key_t       smallest;
        key_t       largest;
        logic       is_empty;
    } set_result_t;

    key_t        store_keys [CAPACITY];
    int          key_count = 0;
    set_result_t expected_results [$];

    // first slot holding a key strictly above k
    function automatic int first_above(input key_t k);
        int i;
        i = 0;
        while (i < key_count && !(k < store_keys[i]))
        begin
            i++;
        end
        return i;
    endfunction

    function automatic set_result_t serve_command(input logic [2:0] act, input key_t k,
                                                  input logic [4:0] ix);
        set_result_t r;
        int          lo;
        int          hi;
        int          i;
        r        = '0;
        r.status = ST_MISS;
        case (act)
            ACT_INSERT:
            begin
                if (key_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // duplicates land after all equal keys
                    hi = first_above(k);
                    for (i = key_count; i > hi; i--)
                    begin
                        store_keys[i] = store_keys[i-1];
                    end
                    store_keys[hi] = k;
                    key_count++;
                    r.status   = ST_DONE;
                    r.position = 4'(hi);
                end
            end
            ACT_REMOVE:
            begin
                if (int'(ix) < key_count)
                begin
                    r.value = store_keys[ix];
                    for (i = int'(ix); i + 1 < key_count; i++)
                    begin
                        store_keys[i] = store_keys[i+1];
                    end
                    key_count--;
                    r.status   = ST_DONE;
                    r.position = 4'(ix);
                end
            end
            ACT_SEARCH, ACT_PRED, ACT_SUCC:
            begin
                lo = 0;
                while (lo < key_count && store_keys[lo] < k)
                begin
                    lo++;
                end
                // neighbors only count when the key itself is held
                if (lo < key_count && store_keys[lo] == k)
                begin
                    if (act == ACT_SEARCH)
                    begin
                        r.status   = ST_DONE;
                        r.value    = k;
                        r.position = 4'(lo);
                    end
                    else if (act == ACT_PRED)
                    begin
                        if (lo > 0)
                        begin
                            r.status   = ST_DONE;
                            r.value    = store_keys[lo-1];
                            r.position = 4'(lo);
                        end
                    end
                    else
                    begin
                        hi = first_above(k);
                        if (hi < key_count)
                        begin
                            r.status   = ST_DONE;
                            r.value    = store_keys[hi];
                            r.position = 4'(lo);
                        end
                    end
                end
            end
            ACT_KTH:
            begin
                if (ix >= 1 && int'(ix) <= key_count)
                begin
                    r.status   = ST_DONE;
                    r.position = 4'(key_count - int'(ix));
                    r.value    = store_keys[key_count - int'(ix)];
                end
            end
            default:
            begin
                r.status = ST_MISS;
            end
        endcase
        r.occupancy = 5'(key_count);
        r.is_empty  = (key_count == 0);
        if (key_count > 0)
        begin
            r.smallest = store_keys[0];
            r.largest  = store_keys[key_count-1];
        end
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        set_result_t want;
        int          bad;
        if (!rst_n)
        begin
            key_count = 0;
            expected_results.delete();
            failures    <= 0;
            outstanding <= 0;
            checked     <= 0;
            full_hits   <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat expected none, got status %0h value %0h",
                             $time, status, value);
                    bad = 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad  = field_mismatch("status", 32'(want.status), 32'(status))
                         + field_mismatch("value", want.value, value)
                         + field_mismatch("position", 32'(want.position), 32'(position))
                         + field_mismatch("occupancy", 32'(want.occupancy), 32'(occupancy))
                         + field_mismatch("smallest", want.smallest, smallest)
                         + field_mismatch("largest", want.largest, largest)
                         + field_mismatch("is_empty", 32'(want.is_empty), 32'(is_empty));
                    if (want.status == ST_FULL)
                    begin
                        full_hits <= full_hits + 1;
                    end
                end
                checked <= checked + 1;
            end
            if (start && !busy)
            begin
                expected_results.push_back(serve_command(action, key, index));
            end
            outstanding <= expected_results.size();
            if (bad != 0)
            begin
                failures <= failures + 1;
            end
        end
    end

endmodule

>>> test/sorted_array_ordered_set_top_tb.sv
module sorted_array_ordered_set_top_tb;

    import saos_pkg::*;

    // codes with no action behind them
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int   RANDOM_ITEMS = 1850;
    localparam int   QUIET_TAIL   = 150;
    localparam int   STALL_LIMIT  = 2000;
    localparam key_t KEY_MIN      = key_t'(32'h8000_0000);
    localparam key_t KEY_MAX      = key_t'(32'h7fff_ffff);

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_QUERY
    } phase_kind_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    key_t        key;
    logic [4:0]  index;
    logic        done;
    logic [1:0]  status;
    key_t        value;
    logic [3:0]  position;
    logic [4:0]  occupancy;
    key_t        smallest;
    key_t        largest;
    logic        is_empty;

    int          failures;
    int          outstanding;
    int          checked;
    int          full_hits;
    int          idle_cycles;
    int          sent_per_action [8];

    key_t        key_pool [8];
    phase_kind_t kind;
    bit          idling_on;
    int          sent;
    int          phase_no;
    int          phase_len;
    int          roll;
    int          n;
    logic [2:0]  act;
    key_t        k;
    logic [4:0]  ix;

    sorted_array_ordered_set_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .key       (key),
        .index     (index),
        .done      (done),
        .status    (status),
        .value     (value),
        .position  (position),
        .occupancy (occupancy),
        .smallest  (smallest),
        .largest   (largest),
        .is_empty  (is_empty)
    );

    sorted_array_ordered_set_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key         (key),
        .index       (index),
        .done        (done),
        .status      (status),
        .value       (value),
        .position    (position),
        .occupancy   (occupancy),
        .smallest    (smallest),
        .largest     (largest),
        .is_empty    (is_empty),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // holds the command beat until the block takes it
    task automatic issue_command(input logic [2:0] a, input key_t kk, input logic [4:0] ii);
        start  <= 1'b1;
        action <= a;
        key    <= kk;
        index  <= ii;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent_per_action[a]++;
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        action      <= ACT_INSERT;
        key         <= '0;
        index       <= '0;
        for (n = 0; n < 8; n++)
        begin
            sent_per_action[n] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries on an empty store
        issue_command(ACT_SEARCH, key_t'(0), 5'd0);
        issue_command(ACT_PRED, key_t'(0), 5'd0);
        issue_command(ACT_KTH, key_t'(0), 5'd1);
        issue_command(ACT_REMOVE, key_t'(0), 5'd0);
        // extremes and a run of duplicates
        issue_command(ACT_INSERT, key_t'(0), 5'd0);
        issue_command(ACT_INSERT, KEY_MIN, 5'd0);
        issue_command(ACT_INSERT, KEY_MAX, 5'd0);
        issue_command(ACT_INSERT, key_t'(-1), 5'd0);
        issue_command(ACT_INSERT, key_t'(5), 5'd0);
        issue_command(ACT_INSERT, key_t'(5), 5'd0);
        issue_command(ACT_INSERT, key_t'(5), 5'd0);
        issue_command(ACT_SEARCH, key_t'(5), 5'd0);
        issue_command(ACT_PRED, key_t'(5), 5'd0);
        issue_command(ACT_SUCC, key_t'(5), 5'd0);
        // no smaller key, no larger key, absent key
        issue_command(ACT_PRED, KEY_MIN, 5'd0);
        issue_command(ACT_SUCC, KEY_MAX, 5'd0);
        issue_command(ACT_SEARCH, key_t'(7), 5'd0);
        issue_command(ACT_PRED, key_t'(7), 5'd0);
        issue_command(ACT_KTH, key_t'(0), 5'd1);
        issue_command(ACT_KTH, key_t'(0), 5'd7);
        issue_command(ACT_KTH, key_t'(0), 5'd0);
        issue_command(ACT_KTH, key_t'(0), 5'd8);
        issue_command(ACT_KTH, key_t'(0), 5'd31);
        issue_command(ACT_SPARE_A, KEY_MAX, 5'd31);
        issue_command(ACT_SPARE_B, KEY_MIN, 5'd0);
        issue_command(ACT_REMOVE, key_t'(0), 5'd31);
        issue_command(ACT_REMOVE, key_t'(0), 5'd0);
        issue_command(ACT_REMOVE, key_t'(0), 5'd5);

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       kind = PH_FILL;
                1:       kind = PH_DRAIN;
                default: kind = PH_QUERY;
            endcase
            idling_on = ($urandom_range(0, 3) != 0) && (sent < RANDOM_ITEMS - QUIET_TAIL);
            // a small pool of keys so that queries often hit and duplicates pile up
            for (n = 0; n < 8; n++)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    key_pool[n] = key_t'($urandom);
                end
                else
                begin
                    key_pool[n] = key_t'(int'($urandom_range(0, 40)) - 20);
                end
            end
            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                case (kind)
                    PH_FILL:
                        act = (roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_REMOVE :
                              3'($urandom_range(ACT_SEARCH, ACT_KTH));
                    PH_DRAIN:
                        act = (roll < 60) ? ACT_REMOVE : (roll < 70) ? ACT_INSERT :
                              3'($urandom_range(ACT_SEARCH, ACT_KTH));
                    default:
                        act = (roll < 20) ? ACT_INSERT : (roll < 30) ? ACT_REMOVE :
                              3'($urandom_range(ACT_SEARCH, ACT_KTH));
                endcase
                if ($urandom_range(0, 39) == 0)
                begin
                    act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
                end
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    k = key_pool[$urandom_range(0, 7)];
                end
                else if (roll < 75)
                begin
                    case ($urandom_range(0, 3))
                        0:       k = KEY_MIN;
                        1:       k = KEY_MAX;
                        2:       k = key_t'(0);
                        default: k = key_t'(-1);
                    endcase
                end
                else
                begin
                    k = key_t'($urandom);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    ix = 5'($urandom_range(0, 31));
                end
                else
                begin
                    ix = 5'($urandom_range(0, 17));
                end
                issue_command(act, k, ix);
                sent++;
                if (idling_on && $urandom_range(0, 3) == 0)
                begin
                    pause_sender($urandom_range(1, 4));
                end
            end
            if (phase_no == 3 || phase_no == 15)
            begin
                drain_results();
            end
            phase_no++;
        end

        drain_results();
        repeat (10) @(posedge clk);
        $display("sent %0d ins, %0d rem, %0d search, %0d pred/succ, %0d kth, %0d spare codes",
                 sent_per_action[ACT_INSERT], sent_per_action[ACT_REMOVE],
                 sent_per_action[ACT_SEARCH],
                 sent_per_action[ACT_PRED] + sent_per_action[ACT_SUCC],
                 sent_per_action[ACT_KTH],
                 sent_per_action[ACT_SPARE_A] + sent_per_action[ACT_SPARE_B]);
        $display("checked %0d results, %0d inserts refused on a full store", checked, full_hits);
        if (failures == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/saos_pkg.sv
hdl/saos_cell.sv
hdl/sorted_array_ordered_set_top.sv
test/sorted_array_ordered_set_checker.sv
test/sorted_array_ordered_set_top_tb.sv
